@@ sv/u2g_pkg.sv @@
// ---------------------------------------------------------------------------
// u2g_pkg: shared types and constants of the UTF-8 to glyph index block
// Item formats, table geometry and the decoder constants.
// ---------------------------------------------------------------------------
package u2g_pkg;

   localparam int TableDepth = 1024;
   localparam int AddrW      = (TableDepth > 1) ? $clog2(TableDepth) : 1;
   localparam int CountW     = $clog2(TableDepth + 1);

   localparam logic [15:0] SubstCode = 16'h25A0;
   localparam logic [31:0] Ucs2Max   = 32'h0000_FFFF;
   localparam logic [7:0]  ContMask  = 8'h3F;

   localparam logic KindLoad = 1'b0;
   localparam logic KindText = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [7:0]  text_byte;
      logic [9:0]  entry_index;
      logic [15:0] range_start;
      logic [15:0] range_end;
   } u2g_req_type;

   typedef struct packed {
      logic [15:0] code_point;
      logic [15:0] glyph_index;
      logic        found;
   } u2g_rsp_type;

   typedef struct packed {
      logic        start;
      logic [15:0] code;
   } u2g_char_type;

   typedef struct packed {
      logic             rd_en;
      logic [AddrW-1:0] rd_addr;
   } u2g_rd_type;

endpackage

@@ sv/u2g_decoder.sv @@
// ---------------------------------------------------------------------------
// u2g_decoder: UTF-8 sequence decoder
// Tracks the bytes still expected and the partial code of the character.
// ---------------------------------------------------------------------------
module u2g_decoder (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  text_accept,
   input  logic [7:0]            text_byte,
   output u2g_pkg::u2g_char_type char_out
);

   logic [2:0]  bytes_left_ff, bytes_left_in;
   logic [31:0] acc_ff, acc_in;
   logic        done;
   logic [2:0]  len;
   logic [7:0]  mask;

   always_comb begin
      len  = 3'd1;
      mask = 8'h7F;
      case (text_byte) inside
         [8'h00:8'hBF]: begin len = 3'd1; mask = 8'h7F; end
         [8'hC0:8'hDF]: begin len = 3'd2; mask = 8'h3F; end
         [8'hE0:8'hEF]: begin len = 3'd3; mask = 8'h1F; end
         [8'hF0:8'hF7]: begin len = 3'd4; mask = 8'h0F; end
         [8'hF8:8'hFB]: begin len = 3'd5; mask = 8'h07; end
         default:       begin len = 3'd6; mask = 8'h03; end
      endcase
   end

   always_comb begin
      if (bytes_left_ff == 3'd0) begin
         acc_in        = {24'd0, text_byte & mask};
         bytes_left_in = len - 3'd1;
         done          = (len == 3'd1);
      end else begin
         acc_in        = {acc_ff[25:0], 6'd0} + {24'd0, text_byte & u2g_pkg::ContMask};
         bytes_left_in = bytes_left_ff - 3'd1;
         done          = (bytes_left_ff == 3'd1);
      end
   end

   assign char_out.start = text_accept && done;
   assign char_out.code  = (acc_in > u2g_pkg::Ucs2Max) ? u2g_pkg::SubstCode : acc_in[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= 3'd0;
         acc_ff        <= 32'd0;
      end else if (text_accept) begin
         bytes_left_ff <= bytes_left_in;
         acc_ff        <= acc_in;
      end
   end

endmodule

@@ sv/u2g_range_ram.sv @@
// ---------------------------------------------------------------------------
// u2g_range_ram: range table storage
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module u2g_range_ram (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [u2g_pkg::AddrW-1:0] wr_addr,
   input  logic [31:0]               wr_data,
   input  u2g_pkg::u2g_rd_type       rd,
   output logic [31:0]               rd_data
);

   logic [31:0] mem [u2g_pkg::TableDepth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.rd_en) begin
         rd_data <= mem[rd.rd_addr];
      end
   end

endmodule

@@ sv/u2g_lookup.sv @@
// ---------------------------------------------------------------------------
// u2g_lookup: range table search and result register
// Streams table entries through the read port and accumulates range sizes.
// ---------------------------------------------------------------------------
module u2g_lookup (
   input  logic                  clock,
   input  logic                  reset,
   input  u2g_pkg::u2g_char_type char_in,
   input  logic [10:0]           range_count,
   output logic                  idle,
   output u2g_pkg::u2g_rd_type   rd,
   input  logic [31:0]           rd_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output u2g_pkg::u2g_rsp_type  rsp_item
);

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StScan = 2'd1;
   localparam logic [1:0] StWait = 2'd2;

   localparam int CW = u2g_pkg::CountW;

   logic [1:0]    state_ff, state_in;
   logic [15:0]   code_ff, code_in;
   logic [15:0]   offset_ff, offset_in;
   logic [CW-1:0] rd_k_ff, rd_k_in;
   logic [CW-1:0] limit_ff, limit_in;
   logic          data_valid_ff, data_valid_in;
   logic          last_ff, last_in;
   logic [15:0]   glyph_ff, glyph_in;
   logic          found_ff, found_in;
   logic          rsp_valid_ff, rsp_valid_in;
   u2g_pkg::u2g_rsp_type rsp_ff, rsp_in;

   logic [CW-1:0] lim;
   logic          issue;
   logic [15:0]   ent_start, ent_end;
   logic          hit;

   assign lim = (32'(range_count) > u2g_pkg::TableDepth) ? CW'(u2g_pkg::TableDepth)
                                                         : CW'(range_count);
   assign ent_start = rd_data[31:16];
   assign ent_end   = rd_data[15:0];
   assign hit       = (ent_start <= code_ff) && (code_ff <= ent_end);
   assign issue     = (state_ff == StScan) && (rd_k_ff < limit_ff);

   assign rd.rd_en   = issue;
   assign rd.rd_addr = rd_k_ff[u2g_pkg::AddrW-1:0];

   always_comb begin
      state_in      = state_ff;
      code_in       = code_ff;
      offset_in     = offset_ff;
      rd_k_in       = rd_k_ff;
      limit_in      = limit_ff;
      data_valid_in = 1'b0;
      last_in       = last_ff;
      glyph_in      = glyph_ff;
      found_in      = found_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         StIdle: begin
            if (char_in.start) begin
               code_in   = char_in.code;
               offset_in = 16'd0;
               rd_k_in   = '0;
               limit_in  = lim;
               glyph_in  = 16'd0;
               found_in  = 1'b0;
               state_in  = (lim == '0) ? StWait : StScan;
            end
         end
         StScan: begin
            if (issue) begin
               rd_k_in       = rd_k_ff + CW'(1);
               data_valid_in = 1'b1;
               last_in       = (rd_k_ff == limit_ff - CW'(1));
            end
            if (data_valid_ff) begin
               if (hit) begin
                  glyph_in      = code_ff - ent_start + offset_ff;
                  found_in      = 1'b1;
                  data_valid_in = 1'b0;
                  state_in      = StWait;
               end else begin
                  offset_in = offset_ff + ent_end - ent_start + 16'd1;
                  if (last_ff) begin
                     data_valid_in = 1'b0;
                     state_in      = StWait;
                  end
               end
            end
         end
         StWait: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_in.code_point  = code_ff;
               rsp_in.glyph_index = glyph_ff;
               rsp_in.found       = found_ff;
               state_in           = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= StIdle;
         data_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         data_valid_ff <= data_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff   <= code_in;
      offset_ff <= offset_in;
      rd_k_ff   <= rd_k_in;
      limit_ff  <= limit_in;
      last_ff   <= last_in;
      glyph_ff  <= glyph_in;
      found_ff  <= found_in;
      rsp_ff    <= rsp_in;
   end

   assign idle      = (state_ff == StIdle);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      char_in.start |-> state_ff == StIdle)
      else $error("character started while a search was running");

   a_data_scan: assert property (@(posedge clock) disable iff (reset)
      data_valid_ff |-> $past(state_ff) == StScan)
      else $error("table data arrived without a read in the scan");

   a_rsp_from_wait: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == StWait)
      else $error("result register loaded outside the wait state");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      rd.rd_en |-> rd_k_ff < limit_ff)
      else $error("table read beyond the range count");

endmodule

@@ sv/utf8_to_glyph_index.sv @@
// ---------------------------------------------------------------------------
// utf8_to_glyph_index: UTF-8 decoder with range table glyph lookup
// Decodes a byte stream into characters and maps each one to a glyph index.
// ---------------------------------------------------------------------------
//   Channel   Direction   Handshake              Contents
//   req_      in          req_valid/req_ready    text byte or table entry load
//   rsp_      out         rsp_valid/rsp_ready    code point, glyph index, found
//   csr_      in          csr_write_enable       range count
//
// A load item or a byte that does not end a character leaves the block ready for the next item.
// A byte that ends a character starts a search of the range table, which reads no
// entry with a range count of zero and otherwise reads entries one a cycle through
// the single read port of the range table.
// Reset clears the decoder and the range count; table contents stay undefined.
// Input items wait while a search runs or while its result waits for the output.
// ---------------------------------------------------------------------------
module utf8_to_glyph_index (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  u2g_pkg::u2g_req_type req_item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output u2g_pkg::u2g_rsp_type rsp_item,
   input  logic                 csr_write_enable,
   input  logic [10:0]          csr_write_data
);

   logic                  accept;
   logic                  text_accept;
   logic                  load_accept;
   logic                  idle;
   logic [10:0]           range_count_ff;
   u2g_pkg::u2g_char_type char_sig;
   u2g_pkg::u2g_rd_type   rd_sig;
   logic [31:0]           rd_data;

   assign req_ready   = idle;
   assign accept      = req_valid && req_ready;
   assign text_accept = accept && (req_item.kind == u2g_pkg::KindText);
   assign load_accept = accept && (req_item.kind == u2g_pkg::KindLoad)
                        && (32'(req_item.entry_index) < u2g_pkg::TableDepth);

   always_ff @(posedge clock) begin
      if (reset) begin
         range_count_ff <= 11'd0;
      end else if (csr_write_enable) begin
         range_count_ff <= csr_write_data;
      end
   end

   u2g_decoder u_decoder (
      .clock       (clock),
      .reset       (reset),
      .text_accept (text_accept),
      .text_byte   (req_item.text_byte),
      .char_out    (char_sig)
   );

   u2g_range_ram u_ram (
      .clock   (clock),
      .wr_en   (load_accept),
      .wr_addr (u2g_pkg::AddrW'(req_item.entry_index)),
      .wr_data ({req_item.range_start, req_item.range_end}),
      .rd      (rd_sig),
      .rd_data (rd_data)
   );

   u2g_lookup u_lookup (
      .clock       (clock),
      .reset       (reset),
      .char_in     (char_sig),
      .range_count (range_count_ff),
      .idle        (idle),
      .rd          (rd_sig),
      .rd_data     (rd_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_item    (rsp_item)
   );

endmodule

@@ sim/utf8_to_glyph_index_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf8_to_glyph_index_tb: self-checking bench for the UTF-8 glyph lookup
// Drives text bytes and range table loads through the request channel, keeps
// its own decoder and table search, and compares every glyph result in order.
// Runs a short directed set, a full table load, then randomised phases with
// different range counts and random stalls on both channels.
// ---------------------------------------------------------------------------

class glyph_predictor;
   logic [15:0] tab_start [u2g_pkg::TableDepth];
   logic [15:0] tab_end [u2g_pkg::TableDepth];
   logic [10:0] range_limit;
   logic [2:0]  cont_left;
   logic [31:0] code_sum;
   u2g_pkg::u2g_rsp_type expected_glyphs [$];
   int          failures;

   function new();
      range_limit = '0;
      cont_left   = '0;
      code_sum    = '0;
      failures    = 0;
      foreach (tab_start[k]) begin
         tab_start[k] = '0;
         tab_end[k]   = '0;
      end
   endfunction

   function void take_item(u2g_pkg::u2g_req_type item);
      logic        done;
      logic [7:0]  b;
      logic [15:0] code;
      logic [15:0] offset;
      u2g_pkg::u2g_rsp_type glyph;
      int          scan;
      int          k;
      if (item.kind == u2g_pkg::KindLoad) begin
         tab_start[item.entry_index] = item.range_start;
         tab_end[item.entry_index]   = item.range_end;
         return;
      end
      b    = item.text_byte;
      done = 1'b0;
      if (cont_left == 0) begin
         if (b < 8'hC0) begin
            code_sum = 32'(b & 8'h7F);
            done     = 1'b1;
         end else if (b < 8'hE0) begin
            code_sum  = 32'(b & 8'h3F);
            cont_left = 3'd1;
         end else if (b < 8'hF0) begin
            code_sum  = 32'(b & 8'h1F);
            cont_left = 3'd2;
         end else if (b < 8'hF8) begin
            code_sum  = 32'(b & 8'h0F);
            cont_left = 3'd3;
         end else if (b < 8'hFC) begin
            code_sum  = 32'(b & 8'h07);
            cont_left = 3'd4;
         end else begin
            code_sum  = 32'(b & 8'h03);
            cont_left = 3'd5;
         end
      end else begin
         code_sum  = (code_sum << 6) + 32'(b & u2g_pkg::ContMask);
         cont_left = cont_left - 3'd1;
         done      = (cont_left == 0);
      end
      if (!done) return;
      code              = (code_sum > u2g_pkg::Ucs2Max) ? u2g_pkg::SubstCode
                                                        : code_sum[15:0];
      glyph.code_point  = code;
      glyph.glyph_index = '0;
      glyph.found       = 1'b0;
      scan   = (range_limit > u2g_pkg::TableDepth) ? u2g_pkg::TableDepth : int'(range_limit);
      offset = '0;
      for (k = 0; k < scan && !glyph.found; k++) begin
         if (tab_start[k] <= code && code <= tab_end[k]) begin
            glyph.glyph_index = code - tab_start[k] + offset;
            glyph.found       = 1'b1;
         end else begin
            offset = offset + tab_end[k] - tab_start[k] + 16'd1;
         end
      end
      expected_glyphs.push_back(glyph);
   endfunction

   function void match_result(u2g_pkg::u2g_rsp_type got);
      u2g_pkg::u2g_rsp_type want;
      if (expected_glyphs.size() == 0) begin
         failures++;
         $display("%0t: unexpected glyph result, expected none, actual %h", $time, got);
         return;
      end
      want = expected_glyphs.pop_front();
      if (got.code_point !== want.code_point) begin
         failures++;
         $display("%0t: code_point expected %h actual %h", $time,
                  want.code_point, got.code_point);
      end
      if (got.glyph_index !== want.glyph_index) begin
         failures++;
         $display("%0t: glyph_index expected %h actual %h", $time,
                  want.glyph_index, got.glyph_index);
      end
      if (got.found !== want.found) begin
         failures++;
         $display("%0t: found expected %b actual %b", $time, want.found, got.found);
      end
   endfunction
endclass

module utf8_to_glyph_index_tb;

   localparam int StallLimit = 20000;
   localparam int NumPhases  = 9;
   localparam logic [5:0][7:0] LeadMark = {8'hFC, 8'hF8, 8'hF0, 8'hE0, 8'hC0, 8'h00};
   localparam logic [5:0][7:0] LeadMask = {8'h03, 8'h03, 8'h07, 8'h0F, 8'h1F, 8'h7F};

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   u2g_pkg::u2g_req_type req_item;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   u2g_pkg::u2g_rsp_type rsp_item;
   logic        csr_write_enable;
   logic [10:0] csr_write_data;

   logic        calm;
   int          items_sent;
   int          stall_cycles = 0;
   int          phase_count [NumPhases] = '{0, 1, 4, 1024, 13, 2047, 64, 7, 300};
   int          phase_items [NumPhases] = '{6, 6, 10, 4, 12, 4, 6, 8, 4};
   glyph_predictor sb;

   utf8_to_glyph_index dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_item         (req_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= !reset && (calm || $urandom_range(0, 99) >= 21);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.take_item(req_item);
         if (rsp_valid && rsp_ready) sb.match_result(rsp_item);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles <= 0;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
         if (stall_cycles >= StallLimit) begin
            $display("utf8_to_glyph_index verification failed");
            $finish;
         end
      end
   end

   task automatic send_item(input u2g_pkg::u2g_req_type item);
      @(negedge clock);
      while (!calm && $urandom_range(0, 99) < 21) begin
         req_valid <= 1'b0;
         @(posedge clock);
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic send_text(input logic [7:0] b);
      u2g_pkg::u2g_req_type item;
      item             = u2g_pkg::u2g_req_type'({$urandom(), $urandom()});
      item.kind        = u2g_pkg::KindText;
      item.text_byte   = b;
      send_item(item);
   endtask

   task automatic send_load(input logic [9:0] slot, input logic [15:0] lo,
                            input logic [15:0] hi);
      u2g_pkg::u2g_req_type item;
      item             = u2g_pkg::u2g_req_type'({$urandom(), $urandom()});
      item.kind        = u2g_pkg::KindLoad;
      item.entry_index = slot;
      item.range_start = lo;
      item.range_end   = hi;
      send_item(item);
   endtask

   task automatic send_char(input logic [31:0] code, input int unsigned len);
      logic [7:0]  b;
      int unsigned i;
      b = 8'(LeadMark[len-1] | ((code >> (6 * (len - 1))) & 32'(LeadMask[len-1])));
      send_text(b);
      for (i = len - 1; i > 0; i--) begin
         b = 8'(32'h80 | ((code >> (6 * (i - 1))) & 32'h3F));
         if ($urandom_range(0, 3) == 0) b[7:6] = 2'($urandom_range(0, 3));
         send_text(b);
      end
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_glyphs.size() != 0) @(posedge clock);
   endtask

   task automatic set_range_count(input logic [10:0] value);
      hold_until_drained();
      repeat (20) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sb.range_limit = value;
   endtask

   function automatic void pick_range(output logic [15:0] lo, output logic [15:0] hi);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      lo   = 16'($urandom());
      hi   = 16'($urandom());
      if (roll < 50) begin
         lo = 16'($urandom_range(0, 16'h07FF));
         hi = 16'(lo + $urandom_range(0, 15));
      end else if (roll < 65) begin
         hi = 16'(lo + $urandom_range(0, 255));
      end else if (roll < 75) begin
         hi = lo;
      end else if (roll < 85) begin
         lo = 16'($urandom_range(0, 16'h7FFF));
         hi = 16'(lo + $urandom_range(0, 16'h7FFF));
      end
   endfunction

   initial begin
      int          p;
      int          k;
      int          first;
      int          reach;
      int unsigned roll;
      int unsigned len;
      logic        paused;
      logic [31:0] code;
      logic [15:0] lo;
      logic [15:0] hi;

      sb               = new();
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_item         = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      calm             = 1'b0;
      items_sent       = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // With no ranges loaded, a zero byte decodes as code 0 and is not found.
      send_text(8'h00);
      send_load(10'd0, 16'h0020, 16'h007E);
      send_load(10'd1, 16'h00A0, 16'h00FF);
      send_load(10'd2, 16'h0400, 16'h03F0);
      send_load(10'd3, u2g_pkg::SubstCode, u2g_pkg::SubstCode);
      send_load(10'd4, 16'h0000, 16'hFFFF);
      set_range_count(11'd5);
      send_text(8'hBF);
      send_text(8'hC2);
      send_text(8'h00);
      // A load in the middle of a sequence leaves the decoder untouched.
      send_text(8'hE4);
      send_load(10'd5, 16'h4E00, 16'h4EFF);
      send_text(8'hB8);
      send_text(8'hAD);
      send_text(8'hF0);
      send_text(8'h9F);
      send_text(8'h98);
      send_text(8'h80);
      send_text(8'hF8);
      send_text(8'h88);
      send_text(8'h80);
      send_text(8'h80);
      send_text(8'h80);
      send_text(8'hFF);
      repeat (5) send_text(8'hBF);

      for (k = 0; k < u2g_pkg::TableDepth; k++) begin
         calm = (k < u2g_pkg::TableDepth / 2);
         pick_range(lo, hi);
         send_load(k[9:0], lo, hi);
      end
      calm = 1'b0;

      for (p = 0; p < NumPhases; p++) begin
         set_range_count(phase_count[p][10:0]);
         calm   = (p == 4);
         paused = 1'b0;
         reach  = (phase_count[p] > u2g_pkg::TableDepth) ? u2g_pkg::TableDepth
                                                         : phase_count[p];
         first  = items_sent;
         while (items_sent - first < phase_items[p]) begin
            if (p == 2 && !paused && items_sent - first >= phase_items[p] / 2) begin
               hold_until_drained();
               paused = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
               roll = $urandom_range(0, 99);
               if (reach > 0 && roll < 75) begin
                  k = $urandom_range(0, reach - 1);
                  if (sb.tab_start[k] <= sb.tab_end[k]) begin
                     code = $urandom_range(sb.tab_end[k], sb.tab_start[k]);
                  end else begin
                     code = 32'(sb.tab_start[k]);
                  end
               end else if (roll < 85) begin
                  code = $urandom() >> $urandom_range(0, 15);
               end else if (roll < 90) begin
                  code = 32'(u2g_pkg::SubstCode);
               end else begin
                  code = $urandom_range(0, 16'hFFFF);
               end
               if (code <= 32'h7F) len = 1;
               else if (code <= 32'h7FF) len = 2;
               else if (code <= 32'hFFFF) len = 3;
               else if (code <= 32'h1F_FFFF) len = 4;
               else if (code <= 32'h3FF_FFFF) len = 5;
               else len = 6;
               if ($urandom_range(0, 4) == 0) len = $urandom_range(6, len);
               send_char(code, len);
            end else if (roll < 88) begin
               send_text(8'($urandom_range(0, 255)));
            end else begin
               pick_range(lo, hi);
               send_load(10'($urandom_range(0, u2g_pkg::TableDepth - 1)), lo, hi);
            end
         end
      end

      hold_until_drained();
      repeat (1100) @(posedge clock);
      if (sb.failures == 0 && sb.expected_glyphs.size() == 0) begin
         $display("utf8_to_glyph_index verification clean");
      end else begin
         $display("utf8_to_glyph_index verification failed");
      end
      $finish;
   end

endmodule
